// ===== rtl/pit_pkg.sv =====
// shared widths and types of the point in triangle test pipeline
package pit_pkg;

	localparam int COORD_WIDTH = 16;
	// coordinate differences
	localparam int DIFF_W = COORD_WIDTH + 1;
	// one product of two differences
	localparam int PROD_W = 2 * DIFF_W;
	// sum of three products
	localparam int DOT_W = PROD_W + 2;
	// split of a dot product for the wide multiply
	localparam int HALF_W = DOT_W / 2;
	localparam int HIGH_W = DOT_W - HALF_W;
	// product of two dot products
	localparam int WIDE_W = 2 * DOT_W;
	// u, v and the area term
	localparam int UVT_W = WIDE_W + 1;
	// w = u + v - t
	localparam int WSUM_W = WIDE_W + 3;
	localparam int STAGES = 7;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
	} pit_coord_t;

	// load enables, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} pit_en_t;

endpackage

// ===== rtl/pit_dot_stage.sv =====
// edge vectors and the five dot products, stages one to three
module pit_dot_stage (
	input  logic                              clk,
	input  pit_pkg::pit_en_t                  en,
	input  pit_pkg::pit_coord_t               pt,
	input  pit_pkg::pit_coord_t               v1,
	input  pit_pkg::pit_coord_t               v2,
	input  pit_pkg::pit_coord_t               v3,
	output logic signed [pit_pkg::DOT_W-1:0]  a,
	output logic signed [pit_pkg::DOT_W-1:0]  b,
	output logic signed [pit_pkg::DOT_W-1:0]  c,
	output logic signed [pit_pkg::DOT_W-1:0]  d,
	output logic signed [pit_pkg::DOT_W-1:0]  e
);

	logic signed [pit_pkg::COORD_WIDTH-1:0] pt_c [3];
	logic signed [pit_pkg::COORD_WIDTH-1:0] v1_c [3];
	logic signed [pit_pkg::COORD_WIDTH-1:0] v2_c [3];
	logic signed [pit_pkg::COORD_WIDTH-1:0] v3_c [3];

	logic signed [pit_pkg::DIFF_W-1:0] e21_s1 [3];
	logic signed [pit_pkg::DIFF_W-1:0] e31_s1 [3];
	logic signed [pit_pkg::DIFF_W-1:0] p_s1 [3];

	logic signed [pit_pkg::PROD_W-1:0] a_pp_s2 [3];
	logic signed [pit_pkg::PROD_W-1:0] b_pp_s2 [3];
	logic signed [pit_pkg::PROD_W-1:0] c_pp_s2 [3];
	logic signed [pit_pkg::PROD_W-1:0] d_pp_s2 [3];
	logic signed [pit_pkg::PROD_W-1:0] e_pp_s2 [3];

	logic signed [pit_pkg::DOT_W-1:0] a_s3, b_s3, c_s3, d_s3, e_s3;

	assign pt_c[0] = pt.x;
	assign pt_c[1] = pt.y;
	assign pt_c[2] = pt.z;
	assign v1_c[0] = v1.x;
	assign v1_c[1] = v1.y;
	assign v1_c[2] = v1.z;
	assign v2_c[0] = v2.x;
	assign v2_c[1] = v2.y;
	assign v2_c[2] = v2.z;
	assign v3_c[0] = v3.x;
	assign v3_c[1] = v3.y;
	assign v3_c[2] = v3.z;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (en.s1) begin
				e21_s1[k] <= pit_pkg::DIFF_W'(v2_c[k]) - pit_pkg::DIFF_W'(v1_c[k]);
				e31_s1[k] <= pit_pkg::DIFF_W'(v3_c[k]) - pit_pkg::DIFF_W'(v1_c[k]);
				p_s1[k]   <= pit_pkg::DIFF_W'(pt_c[k]) - pit_pkg::DIFF_W'(v1_c[k]);
			end
			if (en.s2) begin
				a_pp_s2[k] <= e21_s1[k] * e21_s1[k];
				b_pp_s2[k] <= e21_s1[k] * e31_s1[k];
				c_pp_s2[k] <= e31_s1[k] * e31_s1[k];
				d_pp_s2[k] <= p_s1[k] * e21_s1[k];
				e_pp_s2[k] <= p_s1[k] * e31_s1[k];
			end
		end
		if (en.s3) begin
			a_s3 <= pit_pkg::DOT_W'(a_pp_s2[0]) + pit_pkg::DOT_W'(a_pp_s2[1])
				+ pit_pkg::DOT_W'(a_pp_s2[2]);
			b_s3 <= pit_pkg::DOT_W'(b_pp_s2[0]) + pit_pkg::DOT_W'(b_pp_s2[1])
				+ pit_pkg::DOT_W'(b_pp_s2[2]);
			c_s3 <= pit_pkg::DOT_W'(c_pp_s2[0]) + pit_pkg::DOT_W'(c_pp_s2[1])
				+ pit_pkg::DOT_W'(c_pp_s2[2]);
			d_s3 <= pit_pkg::DOT_W'(d_pp_s2[0]) + pit_pkg::DOT_W'(d_pp_s2[1])
				+ pit_pkg::DOT_W'(d_pp_s2[2]);
			e_s3 <= pit_pkg::DOT_W'(e_pp_s2[0]) + pit_pkg::DOT_W'(e_pp_s2[1])
				+ pit_pkg::DOT_W'(e_pp_s2[2]);
		end
	end

	assign a = a_s3;
	assign b = b_s3;
	assign c = c_s3;
	assign d = d_s3;
	assign e = e_s3;

endmodule

// ===== rtl/pit_wide_mul.sv =====
// signed product of two dot products from four half-width partials, stages four and five
module pit_wide_mul (
	input  logic                               clk,
	input  pit_pkg::pit_en_t                   en,
	input  logic signed [pit_pkg::DOT_W-1:0]   x,
	input  logic signed [pit_pkg::DOT_W-1:0]   y,
	output logic signed [pit_pkg::WIDE_W-1:0]  prod
);

	logic signed [pit_pkg::HIGH_W-1:0] xh, yh;
	logic signed [pit_pkg::HALF_W:0]   xl, yl;

	logic signed [2*pit_pkg::HIGH_W-1:0]          hh_s4;
	logic signed [pit_pkg::HIGH_W+pit_pkg::HALF_W:0] hl_s4, lh_s4;
	logic [2*pit_pkg::HALF_W-1:0]                 ll_s4;

	logic signed [pit_pkg::WIDE_W-1:0] hh_ext, hl_ext, lh_ext, ll_ext;
	logic signed [pit_pkg::WIDE_W-1:0] prod_s5;

	// low halves are unsigned, carried with a zero sign bit
	assign xh = x[pit_pkg::DOT_W-1:pit_pkg::HALF_W];
	assign yh = y[pit_pkg::DOT_W-1:pit_pkg::HALF_W];
	assign xl = $signed({1'b0, x[pit_pkg::HALF_W-1:0]});
	assign yl = $signed({1'b0, y[pit_pkg::HALF_W-1:0]});

	assign hh_ext = pit_pkg::WIDE_W'(hh_s4);
	assign hl_ext = pit_pkg::WIDE_W'(hl_s4);
	assign lh_ext = pit_pkg::WIDE_W'(lh_s4);
	assign ll_ext = $signed(pit_pkg::WIDE_W'(ll_s4));

	always_ff @(posedge clk) begin
		if (en.s4) begin
			hh_s4 <= xh * yh;
			hl_s4 <= xh * yl;
			lh_s4 <= xl * yh;
			ll_s4 <= x[pit_pkg::HALF_W-1:0] * y[pit_pkg::HALF_W-1:0];
		end
		if (en.s5) begin
			prod_s5 <= (hh_ext <<< (2 * pit_pkg::HALF_W)) + (hl_ext <<< pit_pkg::HALF_W)
				+ (lh_ext <<< pit_pkg::HALF_W) + ll_ext;
		end
	end

	assign prod = prod_s5;

endmodule

// ===== rtl/pit_decide.sv =====
// barycentric terms u, v, w and the inside decision, stages six and seven
module pit_decide (
	input  logic                               clk,
	input  pit_pkg::pit_en_t                   en,
	input  logic signed [pit_pkg::WIDE_W-1:0]  dc,
	input  logic signed [pit_pkg::WIDE_W-1:0]  eb,
	input  logic signed [pit_pkg::WIDE_W-1:0]  ea,
	input  logic signed [pit_pkg::WIDE_W-1:0]  db,
	input  logic signed [pit_pkg::WIDE_W-1:0]  ac,
	input  logic signed [pit_pkg::WIDE_W-1:0]  bb,
	output logic                               inside_flag
);

	logic signed [pit_pkg::UVT_W-1:0]  u_s6, v_s6, t_s6;
	logic signed [pit_pkg::WSUM_W-1:0] w_sum;
	logic                              inside_s7;

	assign w_sum = pit_pkg::WSUM_W'(u_s6) + pit_pkg::WSUM_W'(v_s6) - pit_pkg::WSUM_W'(t_s6);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			u_s6 <= pit_pkg::UVT_W'(dc) - pit_pkg::UVT_W'(eb);
			v_s6 <= pit_pkg::UVT_W'(ea) - pit_pkg::UVT_W'(db);
			t_s6 <= pit_pkg::UVT_W'(ac) - pit_pkg::UVT_W'(bb);
		end
		if (en.s7) begin
			// zero w counts as outside, zero u or v as inside
			inside_s7 <= w_sum[pit_pkg::WSUM_W-1] & ~u_s6[pit_pkg::UVT_W-1]
				& ~v_s6[pit_pkg::UVT_W-1];
		end
	end

	assign inside_flag = inside_s7;

endmodule

// ===== rtl/point_in_triangle_test_unit.sv =====
// top level of the point in triangle test pipeline
//
//   channel   handshake               payload
//   input     in_valid / in_ready     point_*, first_*, second_*, third_*
//   output    out_valid / out_ready   inside_res
//
// seven register stages, one transaction per cycle while the output is not stalled,
// the depth set by the two rounds of multiplies and the wide add after the partials
// each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up and a stalled output holds only the stages behind it
// arst_n clears the stage valid bits only

module point_in_triangle_test_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] point_x,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] point_y,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] point_z,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] first_x,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] first_y,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] first_z,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] second_x,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] second_y,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] second_z,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] third_x,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] third_y,
	input  logic signed [pit_pkg::COORD_WIDTH-1:0] third_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   inside_res
);

	logic [pit_pkg::STAGES-1:0] vld_q;
	logic [pit_pkg::STAGES-1:0] rdy;
	logic [pit_pkg::STAGES-1:0] feed;
	logic [pit_pkg::STAGES-1:0] ld;
	pit_pkg::pit_en_t           en;

	pit_pkg::pit_coord_t pt, v1, v2, v3;

	logic signed [pit_pkg::DOT_W-1:0]  a, b, c, d, e;
	logic signed [pit_pkg::WIDE_W-1:0] dc, eb, ea, db, ac, bb;

	// stage ready chain, from the output back to the input
	always_comb begin
		rdy[pit_pkg::STAGES-1] = ~vld_q[pit_pkg::STAGES-1] | out_ready;
		for (int k = pit_pkg::STAGES - 2; k >= 0; k--) begin
			rdy[k] = ~vld_q[k] | rdy[k+1];
		end
	end

	assign feed = {vld_q[pit_pkg::STAGES-2:0], in_valid};
	assign ld   = feed & rdy;

	assign en.s1 = ld[0];
	assign en.s2 = ld[1];
	assign en.s3 = ld[2];
	assign en.s4 = ld[3];
	assign en.s5 = ld[4];
	assign en.s6 = ld[5];
	assign en.s7 = ld[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~rdy) | ld;
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[pit_pkg::STAGES-1];

	assign pt = '{x: point_x, y: point_y, z: point_z};
	assign v1 = '{x: first_x, y: first_y, z: first_z};
	assign v2 = '{x: second_x, y: second_y, z: second_z};
	assign v3 = '{x: third_x, y: third_y, z: third_z};

	pit_dot_stage u_dot (
		.clk (clk),
		.en  (en),
		.pt  (pt),
		.v1  (v1),
		.v2  (v2),
		.v3  (v3),
		.a   (a),
		.b   (b),
		.c   (c),
		.d   (d),
		.e   (e)
	);

	pit_wide_mul u_mul_dc (.clk(clk), .en(en), .x(d), .y(c), .prod(dc));
	pit_wide_mul u_mul_eb (.clk(clk), .en(en), .x(e), .y(b), .prod(eb));
	pit_wide_mul u_mul_ea (.clk(clk), .en(en), .x(e), .y(a), .prod(ea));
	pit_wide_mul u_mul_db (.clk(clk), .en(en), .x(d), .y(b), .prod(db));
	pit_wide_mul u_mul_ac (.clk(clk), .en(en), .x(a), .y(c), .prod(ac));
	pit_wide_mul u_mul_bb (.clk(clk), .en(en), .x(b), .y(b), .prod(bb));

	pit_decide u_decide (
		.clk         (clk),
		.en          (en),
		.dc          (dc),
		.eb          (eb),
		.ea          (ea),
		.db          (db),
		.ac          (ac),
		.bb          (bb),
		.inside_flag (inside_res)
	);

endmodule

// ===== test/point_in_triangle_test_unit_tb.sv =====
// testbench of the point in triangle test unit: queued queries, stalls, predicted inside flag
`timescale 1ns / 1ps

module point_in_triangle_test_unit_tb;

	localparam int CMAX = 32767;
	localparam int CMIN = -32768;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_QUERIES = 1950;

	typedef struct packed {
		pit_pkg::pit_coord_t point;
		pit_pkg::pit_coord_t first;
		pit_pkg::pit_coord_t second;
		pit_pkg::pit_coord_t third;
	} tri_query_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	logic inside_res;
	tri_query_t cur_query = '0;

	tri_query_t pending_queries[$];
	bit expected_inside[$];
	bit in_taken = 1'b0;
	bit want_inside;
	int sent_count = 0;
	int stall_cycles = 0;
	int error_count = 0;
	bit no_idle;

	always #10 clk = ~clk;

	point_in_triangle_test_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.point_x    (cur_query.point.x),
		.point_y    (cur_query.point.y),
		.point_z    (cur_query.point.z),
		.first_x    (cur_query.first.x),
		.first_y    (cur_query.first.y),
		.first_z    (cur_query.first.z),
		.second_x   (cur_query.second.x),
		.second_y   (cur_query.second.y),
		.second_z   (cur_query.second.z),
		.third_x    (cur_query.third.x),
		.third_y    (cur_query.third.y),
		.third_z    (cur_query.third.z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.inside_res (inside_res)
	);

	// exact barycentric test on wide signed integers
	function automatic bit inside_expected(input tri_query_t q);
		logic signed [127:0] e21[3];
		logic signed [127:0] e31[3];
		logic signed [127:0] rel[3];
		logic signed [127:0] a, b, c, d, e, u, v, w;
		e21[0] = q.second.x - q.first.x;
		e21[1] = q.second.y - q.first.y;
		e21[2] = q.second.z - q.first.z;
		e31[0] = q.third.x - q.first.x;
		e31[1] = q.third.y - q.first.y;
		e31[2] = q.third.z - q.first.z;
		rel[0] = q.point.x - q.first.x;
		rel[1] = q.point.y - q.first.y;
		rel[2] = q.point.z - q.first.z;
		a = e21[0] * e21[0] + e21[1] * e21[1] + e21[2] * e21[2];
		b = e21[0] * e31[0] + e21[1] * e31[1] + e21[2] * e31[2];
		c = e31[0] * e31[0] + e31[1] * e31[1] + e31[2] * e31[2];
		d = rel[0] * e21[0] + rel[1] * e21[1] + rel[2] * e21[2];
		e = rel[0] * e31[0] + rel[1] * e31[1] + rel[2] * e31[2];
		u = d * c - e * b;
		v = e * a - d * b;
		w = u + v - (a * c - b * b);
		return (w < 0) && (u >= 0) && (v >= 0);
	endfunction

	function automatic tri_query_t mk_query(input int px, py, pz, ax, ay, az,
			bx, by, bz, cx, cy, cz);
		tri_query_t q;
		q.point.x = px[pit_pkg::COORD_WIDTH-1:0];
		q.point.y = py[pit_pkg::COORD_WIDTH-1:0];
		q.point.z = pz[pit_pkg::COORD_WIDTH-1:0];
		q.first.x = ax[pit_pkg::COORD_WIDTH-1:0];
		q.first.y = ay[pit_pkg::COORD_WIDTH-1:0];
		q.first.z = az[pit_pkg::COORD_WIDTH-1:0];
		q.second.x = bx[pit_pkg::COORD_WIDTH-1:0];
		q.second.y = by[pit_pkg::COORD_WIDTH-1:0];
		q.second.z = bz[pit_pkg::COORD_WIDTH-1:0];
		q.third.x = cx[pit_pkg::COORD_WIDTH-1:0];
		q.third.y = cy[pit_pkg::COORD_WIDTH-1:0];
		q.third.z = cz[pit_pkg::COORD_WIDTH-1:0];
		return q;
	endfunction

	// index 0 is the point, 1..3 the vertices
	task automatic queue_random_query();
		int x[4], y[4], z[4];
		int pick, kind, span, bx, by, bz, wa, wb, wc, s, k;
		pick = $urandom_range(99);
		if (pick < 25) begin
			for (k = 0; k < 4; k++) begin
				x[k] = $urandom;
				y[k] = $urandom;
				z[k] = $urandom;
			end
		end else if (pick < 65) begin
			// point as a weighted mix of the vertices, mostly inside
			span = 1 << $urandom_range(14, 2);
			for (k = 1; k < 4; k++) begin
				x[k] = $urandom_range(2 * span) - span;
				y[k] = $urandom_range(2 * span) - span;
				z[k] = $urandom_range(2 * span) - span;
			end
			wa = $urandom_range(100);
			wb = $urandom_range(100);
			wc = $urandom_range(100, 1);
			s = wa + wb + wc;
			x[0] = (x[1] * wa + x[2] * wb + x[3] * wc) / s;
			y[0] = (y[1] * wa + y[2] * wb + y[3] * wc) / s;
			z[0] = (z[1] * wa + z[2] * wb + z[3] * wc) / s;
		end else if (pick < 90) begin
			// small cluster anywhere in the range
			span = 1 << $urandom_range(10, 1);
			bx = $urandom_range(63487) - 31744;
			by = $urandom_range(63487) - 31744;
			bz = $urandom_range(63487) - 31744;
			for (k = 0; k < 4; k++) begin
				x[k] = bx + $urandom_range(2 * span) - span;
				y[k] = by + $urandom_range(2 * span) - span;
				z[k] = bz + $urandom_range(2 * span) - span;
			end
		end else begin
			span = 1 << $urandom_range(12, 1);
			for (k = 0; k < 4; k++) begin
				x[k] = ($urandom_range(2 * span) - span) & ~1;
				y[k] = ($urandom_range(2 * span) - span) & ~1;
				z[k] = ($urandom_range(2 * span) - span) & ~1;
			end
			kind = $urandom_range(2);
			if (kind == 0) begin
				// collinear vertices
				wa = $urandom_range(3) - 1;
				x[3] = x[1] + wa * (x[2] - x[1]);
				y[3] = y[1] + wa * (y[2] - y[1]);
				z[3] = z[1] + wa * (z[2] - z[1]);
			end else if (kind == 1) begin
				k = $urandom_range(3, 1);
				x[0] = x[k];
				y[0] = y[k];
				z[0] = z[k];
			end else begin
				// midpoint of the far edge
				x[0] = (x[2] + x[3]) / 2;
				y[0] = (y[2] + y[3]) / 2;
				z[0] = (z[2] + z[3]) / 2;
			end
		end
		pending_queries.push_back(mk_query(x[0], y[0], z[0], x[1], y[1], z[1],
			x[2], y[2], z[2], x[3], y[3], z[3]));
	endtask

	assign no_idle = (sent_count >= 700) && (sent_count < 1000);

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_queries.size() > 0 && (no_idle || $urandom_range(99) >= 33)) begin
					cur_query <= pending_queries.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= no_idle || ($urandom_range(99) >= 33);
		end
	end

	// monitor, scoreboard and watchdog
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			expected_inside.push_back(inside_expected(cur_query));
			sent_count++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_inside.size() == 0) begin
				$display("%0t: result with no transaction pending, expected none, got inside_res=%0b",
					$time, inside_res);
				error_count++;
			end else begin
				want_inside = expected_inside.pop_front();
				if (inside_res !== want_inside) begin
					$display("%0t: inside_res mismatch, expected %0b, got %0b",
						$time, want_inside, inside_res);
					error_count++;
				end
			end
		end
		if (arst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
			stall_cycles++;
		else
			stall_cycles = 0;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		// zero, extremes and alternating bit patterns
		pending_queries.push_back(mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_queries.push_back(mk_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
			CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
		pending_queries.push_back(mk_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
			CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
		pending_queries.push_back(mk_query(CMIN, CMAX, CMIN, CMIN, CMIN, CMIN,
			CMAX, CMAX, CMAX, CMAX, CMIN, CMAX));
		pending_queries.push_back(mk_query(0, 0, 0, CMAX, CMAX, CMAX,
			CMIN, CMIN, CMIN, CMIN, CMAX, CMIN));
		pending_queries.push_back(mk_query(CMIN, CMIN, CMIN, CMIN, CMIN, 0,
			CMAX, CMIN, 0, CMIN, CMAX, 0));
		pending_queries.push_back(mk_query(0, 0, CMAX, CMIN, CMIN, 0,
			CMAX, CMIN, 0, CMIN, CMAX, 0));
		pending_queries.push_back(mk_query(21845, 21845, 21845, -21846, -21846, -21846,
			21845, -21846, 21845, -21846, 21845, -21846));
		// plain triangle: inside, at each vertex, on edges, outside
		pending_queries.push_back(mk_query(10, 10, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		pending_queries.push_back(mk_query(0, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		pending_queries.push_back(mk_query(100, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		pending_queries.push_back(mk_query(0, 100, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		pending_queries.push_back(mk_query(50, 50, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		pending_queries.push_back(mk_query(50, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		pending_queries.push_back(mk_query(200, 200, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		pending_queries.push_back(mk_query(-10, 10, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		pending_queries.push_back(mk_query(10, -10, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		pending_queries.push_back(mk_query(10, 10, 5000, 0, 0, 0, 100, 0, 0, 0, 100, 0));
		// two degenerate triangles and one general triangle
		pending_queries.push_back(mk_query(5, 5, 5, 0, 0, 0, 10, 10, 10, 20, 20, 20));
		pending_queries.push_back(mk_query(7, -3, 2, 4, 4, 4, 4, 4, 4, 4, 4, 4));
		pending_queries.push_back(mk_query(-150, -250, -50, -100, -200, -300,
			-300, -200, -100, -200, -400, -100));
		repeat (RANDOM_QUERIES) queue_random_query();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_queries.size() > 0 || in_valid) @(posedge clk);
		while (expected_inside.size() > 0) @(posedge clk);
		repeat (3 * pit_pkg::STAGES) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
